FILE: hdl/u8dec_pkg.sv
// shared types, constants and decode functions for the utf-8 byte stream decoder
package u8dec_pkg;

  localparam int MaxSeqBytes = 6;
  localparam int HeldDepth   = MaxSeqBytes - 1;

  localparam logic [15:0] SubstUnit = 16'h003F;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] count_t;
  typedef byte_t [MaxSeqBytes-1:0] seq_buf_t;

  // one request from the front to the back: bytes to decode, then optionally a terminator
  typedef struct packed {
    seq_buf_t bytes;
    count_t   count;
    logic     term;
  } cmd_t;

  // length announced by a lead byte, zero if it cannot lead
  function automatic count_t seq_length(byte_t c);
    count_t len;
    if (c < 8'h80) begin
      len = 3'd1;
    end else if (!c[6]) begin
      len = 3'd0;
    end else if (c < 8'hE0) begin
      len = 3'd2;
    end else if (c < 8'hF0) begin
      len = 3'd3;
    end else if (c < 8'hF8) begin
      len = 3'd4;
    end else if (c < 8'hFC) begin
      len = 3'd5;
    end else if (c < 8'hFE) begin
      len = 3'd6;
    end else begin
      len = 3'd0;
    end
    if (int'(len) > MaxSeqBytes) begin
      len = 3'd0;
    end
    return len;
  endfunction

  // lead plus continuation bits, values past the basic plane become the substitute
  function automatic logic [15:0] compose_unit(seq_buf_t b, count_t len);
    logic [30:0] v;
    v = '0;
    case (len)
      3'd2: v = {20'd0, b[0][4:0], b[1][5:0]};
      3'd3: v = {15'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      3'd4: v = {10'd0, b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      3'd5: v = {5'd0, b[0][1:0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0]};
      3'd6: v = {b[0][0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0], b[5][5:0]};
      default: v = {23'd0, b[0]};
    endcase
    return (v[30:16] != '0) ? SubstUnit : v[15:0];
  endfunction

endpackage

FILE: hdl/u8dec_ifs.sv
// byte and code unit channel interfaces
interface u8dec_byte_if;
  logic              valid;
  logic              ready;
  u8dec_pkg::byte_t  data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface u8dec_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_in_run;
  logic        end_of_string;

  modport source(output valid, output code_unit, output last_in_run, output end_of_string,
                 input ready);
  modport sink(input valid, input code_unit, input last_in_run, input end_of_string,
               output ready);
endinterface

FILE: hdl/u8dec_front.sv
// front end: takes bytes, gathers sequences and issues decode requests
module u8dec_front (
  input  logic              clk,
  input  logic              rst,
  u8dec_byte_if.sink        text_bytes,
  output u8dec_pkg::cmd_t   cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  u8dec_pkg::byte_t   pending [u8dec_pkg::HeldDepth];
  u8dec_pkg::count_t  held;
  u8dec_pkg::count_t  expected;
  u8dec_pkg::count_t  held_next;
  u8dec_pkg::count_t  expected_next;
  u8dec_pkg::count_t  lead_len;
  u8dec_pkg::seq_buf_t merged;
  u8dec_pkg::byte_t   b;
  logic               accept;
  logic               write_en;

  assign text_bytes.ready = cmd_ready;
  assign accept = text_bytes.valid && cmd_ready;
  assign b = text_bytes.data_byte;
  assign lead_len = u8dec_pkg::seq_length(b);

  // held bytes with the incoming byte dropped into the next free slot
  always_comb begin
    for (int i = 0; i < u8dec_pkg::HeldDepth; i++) begin
      merged[i] = (held == u8dec_pkg::count_t'(i)) ? b : pending[i];
    end
    merged[u8dec_pkg::HeldDepth] = b;
  end

  always_comb begin
    held_next     = held;
    expected_next = expected;
    write_en      = 1'b0;
    cmd_valid     = 1'b0;
    cmd.bytes     = merged;
    cmd.count     = held;
    cmd.term      = 1'b0;
    if (b == '0) begin
      // end of string: flush whatever is held, then terminate
      cmd_valid     = accept;
      cmd.term      = 1'b1;
      held_next     = '0;
      expected_next = '0;
    end else if (held == '0) begin
      if (lead_len <= 3'd1) begin
        cmd_valid = accept;
        cmd.count = 3'd1;
      end else begin
        write_en      = 1'b1;
        held_next     = 3'd1;
        expected_next = lead_len;
      end
    end else if (({1'b0, held} + 4'd1) < {1'b0, expected}) begin
      write_en  = 1'b1;
      held_next = held + 3'd1;
    end else begin
      cmd_valid     = accept;
      cmd.count     = expected;
      held_next     = '0;
      expected_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      expected <= '0;
    end else if (accept) begin
      held     <= held_next;
      expected <= expected_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < u8dec_pkg::HeldDepth; i++) begin
      if (accept && write_en && held == u8dec_pkg::count_t'(i)) begin
        pending[i] <= b;
      end
    end
  end

endmodule

FILE: hdl/u8dec_queue.sv
// two-entry request queue between front and back
module u8dec_queue (
  input  logic             clk,
  input  logic             rst,
  input  u8dec_pkg::cmd_t  push_cmd,
  input  logic             push_valid,
  output logic             push_ready,
  output u8dec_pkg::cmd_t  pop_cmd,
  output logic             pop_valid,
  input  logic             pop_ready
);

  u8dec_pkg::cmd_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hdl/u8dec_back.sv
// back end: walks a request, one code unit per cycle unless stalled, into the output register
module u8dec_back (
  input  logic             clk,
  input  logic             rst,
  input  u8dec_pkg::cmd_t  cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  u8dec_unit_if.source     code_units
);

  logic                busy;
  u8dec_pkg::seq_buf_t wbuf;
  u8dec_pkg::count_t   wcnt;
  logic                wterm;

  logic                out_valid;
  logic [15:0]         out_unit;
  logic                out_last;
  logic                out_eos;

  u8dec_pkg::byte_t    lead;
  u8dec_pkg::count_t   len;
  u8dec_pkg::count_t   adv;
  u8dec_pkg::count_t   rem;
  u8dec_pkg::seq_buf_t shifted;
  logic                fits;
  logic [15:0]         unit;
  logic                eos;
  logic                final_unit;
  logic                step;
  logic                load;

  assign lead = wbuf[0];
  assign len  = u8dec_pkg::seq_length(lead);
  assign fits = (len >= 3'd2) && (len <= wcnt);

  always_comb begin
    if (wcnt != '0) begin
      unit = fits ? u8dec_pkg::compose_unit(wbuf, len) : {8'd0, lead};
      adv  = fits ? len : 3'd1;
      eos  = 1'b0;
    end else begin
      unit = '0;
      adv  = '0;
      eos  = 1'b1;
    end
  end

  assign rem        = wcnt - adv;
  assign shifted    = u8dec_pkg::seq_buf_t'(wbuf >> {adv, 3'b000});
  assign final_unit = (wcnt == '0) || ((rem == '0) && !wterm);
  assign step       = busy && (!out_valid || code_units.ready);
  // next request comes in as the current one gives its last unit
  assign load       = !busy || (step && final_unit);
  assign cmd_ready  = load;

  assign code_units.valid         = out_valid;
  assign code_units.code_unit     = out_unit;
  assign code_units.last_in_run   = out_last;
  assign code_units.end_of_string = out_eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= cmd_valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (code_units.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wbuf  <= cmd.bytes;
      wcnt  <= cmd.count;
      wterm <= cmd.term;
    end else if (step) begin
      wbuf <= shifted;
      wcnt <= rem;
    end
    if (step) begin
      out_unit <= unit;
      out_last <= final_unit;
      out_eos  <= eos;
    end
  end

endmodule

FILE: hdl/utf8_to_ucs2_stream_decoder_top.sv
// utf-8 to 16-bit code unit stream decoder, top level
// text_bytes carries one byte per request (valid/ready); a zero byte ends the string.
// code_units carries one 16-bit unit per request, with last_in_run on the final unit
// that a byte causes and end_of_string on the terminating zero.
// a byte that completes a sequence, or a plain or stray byte, gives one unit; bytes
// inside a sequence give none; a zero byte gives the raw held bytes (re-decoded) and
// then the terminator, up to six units in all.
// a unit passes the request queue, the back end work buffer and the output register.
// throughput: one byte per cycle while each byte gives at most one unit and the
// receiver keeps up; the back end produces one unit per cycle then, so a flush holds
// the front once the two-entry request queue between front and back has filled.
// a stalled receiver holds the output register; the back end stops, the queue fills
// and text_bytes.ready drops. no byte or unit is dropped.
// rst (synchronous, active high) empties the queue and output and drops any partly
// gathered sequence.
module utf8_to_ucs2_stream_decoder_top (
  input  logic          clk,
  input  logic          rst,
  u8dec_byte_if.sink    text_bytes,
  u8dec_unit_if.source  code_units
);

  u8dec_pkg::cmd_t front_cmd;
  logic            front_valid;
  logic            front_ready;
  u8dec_pkg::cmd_t back_cmd;
  logic            back_valid;
  logic            back_ready;

  u8dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_bytes (text_bytes),
    .cmd        (front_cmd),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready)
  );

  u8dec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  u8dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .code_units (code_units)
  );

`ifndef SYNTHESIS
  a_eos_is_last_zero: assert property (@(posedge clk) disable iff (rst)
    code_units.valid && code_units.end_of_string |->
      code_units.last_in_run && code_units.code_unit == 16'd0)
    else $error("terminator not a final zero unit");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    code_units.valid && code_units.ready && !code_units.last_in_run |=> code_units.valid)
    else $error("gap inside a run of units");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> front_ready)
    else $error("request pushed into a full queue");
`endif

endmodule
